[rtl/escll1_pkg.sv]
// Shared types, symbol and token codes, and byte classification for the LL(1) checker.
package escll1_pkg;

  typedef logic [2:0] sym_t;
  typedef logic [3:0] tok_t;
  typedef logic [1:0] verdict_t;
  typedef logic [1:0] op_t;

  // Grammar symbols held on the stack
  localparam sym_t SYM_END = 3'd0;
  localparam sym_t SYM_E   = 3'd1;
  localparam sym_t SYM_EP  = 3'd2;
  localparam sym_t SYM_T   = 3'd3;
  localparam sym_t SYM_TP  = 3'd4;
  localparam sym_t SYM_F   = 3'd5;
  localparam sym_t SYM_RP  = 3'd6;

  // Tokens
  localparam tok_t TK_ID    = 4'd0;
  localparam tok_t TK_PLUS  = 4'd1;
  localparam tok_t TK_MINUS = 4'd2;
  localparam tok_t TK_MUL   = 4'd3;
  localparam tok_t TK_DIV   = 4'd4;
  localparam tok_t TK_LP    = 4'd5;
  localparam tok_t TK_RP    = 4'd6;
  localparam tok_t TK_OTHER = 4'd7;
  localparam tok_t TK_END   = 4'd8;

  // Verdicts
  localparam verdict_t V_PENDING = 2'd0;
  localparam verdict_t V_ACCEPT  = 2'd1;
  localparam verdict_t V_REJECT  = 2'd2;

  // Stack operations chosen by the parse table
  localparam op_t OP_PUSH = 2'd0;
  localparam op_t OP_POP  = 2'd1;
  localparam op_t OP_STOP = 2'd2;

  typedef struct packed {
    op_t      op;       // replace top by two, pop, or finish the token
    sym_t     lower;    // symbol left under the new top on a push
    sym_t     upper;    // new top on a push
    logic     last;     // token consumed after this push or pop
    verdict_t verdict;  // outcome on a stop
  } act_t;

  function automatic logic is_letter(logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) || (b >= 8'hC0);
  endfunction

  function automatic tok_t classify(logic [7:0] b);
    tok_t t;
    case (b)
      8'h2B:   t = TK_PLUS;
      8'h2D:   t = TK_MINUS;
      8'h2A:   t = TK_MUL;
      8'h2F:   t = TK_DIV;
      8'h28:   t = TK_LP;
      8'h29:   t = TK_RP;
      default: t = TK_OTHER;
    endcase
    return t;
  endfunction

endpackage

[rtl/escll1_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module escll1_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/escll1_table.sv]
// Predictive parse table: picks the stack action for the top symbol and current token.
module escll1_table (
  input  escll1_pkg::sym_t top_sym,
  input  escll1_pkg::tok_t tok,
  input  logic             full,
  output escll1_pkg::act_t act
);

  escll1_pkg::act_t raw;

  always_comb begin
    raw.op      = escll1_pkg::OP_STOP;
    raw.lower   = escll1_pkg::SYM_END;
    raw.upper   = escll1_pkg::SYM_END;
    raw.last    = 1'b0;
    raw.verdict = escll1_pkg::V_REJECT;
    unique case (top_sym)
      escll1_pkg::SYM_E: begin
        raw.op    = escll1_pkg::OP_PUSH;
        raw.lower = escll1_pkg::SYM_EP;
        raw.upper = escll1_pkg::SYM_T;
      end
      escll1_pkg::SYM_T: begin
        raw.op    = escll1_pkg::OP_PUSH;
        raw.lower = escll1_pkg::SYM_TP;
        raw.upper = escll1_pkg::SYM_F;
      end
      escll1_pkg::SYM_EP: begin
        if (tok == escll1_pkg::TK_PLUS || tok == escll1_pkg::TK_MINUS) begin
          raw.op    = escll1_pkg::OP_PUSH;
          raw.lower = escll1_pkg::SYM_EP;
          raw.upper = escll1_pkg::SYM_T;
          raw.last  = 1'b1;
        end else begin
          raw.op = escll1_pkg::OP_POP;  // epsilon
        end
      end
      escll1_pkg::SYM_TP: begin
        if (tok == escll1_pkg::TK_MUL || tok == escll1_pkg::TK_DIV) begin
          raw.op    = escll1_pkg::OP_PUSH;
          raw.lower = escll1_pkg::SYM_TP;
          raw.upper = escll1_pkg::SYM_F;
          raw.last  = 1'b1;
        end else begin
          raw.op = escll1_pkg::OP_POP;  // epsilon
        end
      end
      escll1_pkg::SYM_F: begin
        if (tok == escll1_pkg::TK_ID) begin
          raw.op   = escll1_pkg::OP_POP;
          raw.last = 1'b1;
        end else if (tok == escll1_pkg::TK_LP) begin
          raw.op    = escll1_pkg::OP_PUSH;
          raw.lower = escll1_pkg::SYM_RP;
          raw.upper = escll1_pkg::SYM_E;
          raw.last  = 1'b1;
        end
      end
      escll1_pkg::SYM_RP: begin
        if (tok == escll1_pkg::TK_RP) begin
          raw.op   = escll1_pkg::OP_POP;
          raw.last = 1'b1;
        end
      end
      escll1_pkg::SYM_END: begin
        if (tok == escll1_pkg::TK_END) begin
          raw.verdict = escll1_pkg::V_ACCEPT;
        end
      end
      default: begin
        raw.verdict = escll1_pkg::V_REJECT;
      end
    endcase
  end

  // Overflow: a push on a full stack rejects
  always_comb begin
    act = raw;
    if (raw.op == escll1_pkg::OP_PUSH && full) begin
      act.op      = escll1_pkg::OP_STOP;
      act.verdict = escll1_pkg::V_REJECT;
    end
  end

endmodule

[rtl/expression_syntax_checker_ll1_unit.sv]
// Top level: byte tokenizer, stack sequencer and output register of the LL(1) checker.
// Timing: a byte that needs no parsing (continued identifier, sticky rejection) goes
//   straight to the done state, else the table steps once a cycle until the token is
//   consumed or a stop (reject, accept, overflow) ends it; pops wait on the RAM read.
// Throughput: one beat at a time, the next taken once the verdict is in the output
//   register. Reset clears the sequencer and sets the stack to E over END.
module expression_syntax_checker_ll1_unit #(
  parameter int STACK_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] char_byte,
  input  logic       is_end,
  input  logic       in_valid,
  output logic       in_ready,
  output logic [1:0] verdict,
  output logic       out_valid,
  input  logic       out_ready
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_POP  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]           state;
  escll1_pkg::sym_t     top_sym;   // top of stack lives here, the rest in the RAM
  logic [DW-1:0]        depth;     // entries in use, counting the top
  logic                 in_ident;
  logic                 rejected;
  escll1_pkg::tok_t     tok;
  logic                 pop_last;
  escll1_pkg::verdict_t result;

  escll1_pkg::act_t     act;
  logic                 full;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [AW-1:0]        rd_addr;
  escll1_pkg::sym_t     rd_data;
  logic                 out_free;

  // Entry 0 is always END and is never read from the RAM: a pop down to one
  // entry exposes END directly, so the RAM needs no clearing after reset.
  assign full    = (depth >= DW'(STACK_DEPTH));
  assign wr_en   = (state == ST_RUN) && (act.op == escll1_pkg::OP_PUSH);
  assign wr_addr = AW'(depth - DW'(1));
  assign rd_addr = AW'(depth - DW'(2));

  escll1_table u_table (
    .top_sym (top_sym),
    .tok     (tok),
    .full    (full),
    .act     (act)
  );

  escll1_ram #(
    .WIDTH ($bits(escll1_pkg::sym_t)),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (act.lower),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      top_sym   <= escll1_pkg::SYM_E;
      depth     <= DW'(2);
      in_ident  <= 1'b0;
      rejected  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Drop the output beat once taken, unless a fresh verdict loads below
      if (out_valid && out_ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (is_end) begin
              if (rejected) begin
                // Sticky rejection: answer reject and restart without parsing
                result   <= escll1_pkg::V_REJECT;
                top_sym  <= escll1_pkg::SYM_E;
                depth    <= DW'(2);
                in_ident <= 1'b0;
                rejected <= 1'b0;
                state    <= ST_DONE;
              end else begin
                tok   <= escll1_pkg::TK_END;
                state <= ST_RUN;
              end
            end else if (rejected) begin
              result <= escll1_pkg::V_REJECT;
              state  <= ST_DONE;
            end else if (escll1_pkg::is_letter(char_byte)) begin
              if (in_ident) begin
                // Later letters of an identifier add no token
                result <= escll1_pkg::V_PENDING;
                state  <= ST_DONE;
              end else begin
                in_ident <= 1'b1;
                tok      <= escll1_pkg::TK_ID;
                state    <= ST_RUN;
              end
            end else begin
              in_ident <= 1'b0;
              tok      <= escll1_pkg::classify(char_byte);
              state    <= ST_RUN;
            end
          end
        end

        ST_RUN: begin
          unique case (act.op)
            escll1_pkg::OP_PUSH: begin
              // Lower symbol goes to the RAM, upper stays in the top register
              top_sym <= act.upper;
              depth   <= depth + DW'(1);
              if (act.last) begin
                result <= escll1_pkg::V_PENDING;
                state  <= ST_DONE;
              end
            end
            escll1_pkg::OP_POP: begin
              // RAM read of the entry below is already under way
              depth    <= depth - DW'(1);
              pop_last <= act.last;
              state    <= ST_POP;
            end
            escll1_pkg::OP_STOP: begin
              result <= act.verdict;
              if (tok == escll1_pkg::TK_END) begin
                top_sym  <= escll1_pkg::SYM_E;
                depth    <= DW'(2);
                in_ident <= 1'b0;
                rejected <= 1'b0;
              end else begin
                rejected <= 1'b1;
              end
              state <= ST_DONE;
            end
            default: begin
              result <= escll1_pkg::V_REJECT;
              state  <= ST_DONE;
            end
          endcase
        end

        ST_POP: begin
          top_sym <= (depth == DW'(1)) ? escll1_pkg::SYM_END : rd_data;
          if (pop_last) begin
            result <= escll1_pkg::V_PENDING;
            state  <= ST_DONE;
          end else begin
            state <= ST_RUN;
          end
        end

        ST_DONE: begin
          // Hold the verdict until the output register frees up
          if (out_free) begin
            verdict   <= result;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[tb/sv/expression_syntax_checker_ll1_unit_scoreboard.sv]
// Verdict predictor and scoreboard for the LL(1) expression checker.
`timescale 1ns / 100ps

module expression_syntax_checker_ll1_unit_scoreboard #(
  parameter int STACK_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] char_byte,
  input  logic       is_end,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [1:0] verdict,
  input  logic       out_valid,
  input  logic       out_ready,
  output int         fail_count,
  output int         verdicts_due,
  output int         accepts_seen
);

  escll1_pkg::sym_t     sym_stack [STACK_DEPTH];
  int                   sp;
  bit                   in_name;
  bit                   rejected;
  escll1_pkg::verdict_t due_verdicts [$];

  function automatic void restart_parse();
    for (int i = 0; i < STACK_DEPTH; i++) sym_stack[i] = escll1_pkg::SYM_END;
    sym_stack[1] = escll1_pkg::SYM_E;
    sp       = 2;
    in_name  = 1'b0;
    rejected = 1'b0;
  endfunction

  // Replace the top symbol by lower, with upper above it.
  function automatic bit grow(escll1_pkg::sym_t lower, escll1_pkg::sym_t upper);
    if (sp == 0 || sp >= STACK_DEPTH) return 1'b0;
    sym_stack[sp-1] = lower;
    sym_stack[sp]   = upper;
    sp++;
    return 1'b1;
  endfunction

  function automatic escll1_pkg::verdict_t feed_token(escll1_pkg::tok_t tok);
    int               guard;
    escll1_pkg::sym_t top;
    for (guard = 0; guard < 4 * STACK_DEPTH + 16; guard++) begin
      if (sp == 0 || sp > STACK_DEPTH) return escll1_pkg::V_REJECT;
      top = sym_stack[sp-1];
      case (top)
        escll1_pkg::SYM_E: begin
          if (!grow(escll1_pkg::SYM_EP, escll1_pkg::SYM_T)) return escll1_pkg::V_REJECT;
        end
        escll1_pkg::SYM_T: begin
          if (!grow(escll1_pkg::SYM_TP, escll1_pkg::SYM_F)) return escll1_pkg::V_REJECT;
        end
        escll1_pkg::SYM_EP: begin
          if (tok == escll1_pkg::TK_PLUS || tok == escll1_pkg::TK_MINUS) begin
            return grow(escll1_pkg::SYM_EP, escll1_pkg::SYM_T) ?
                   escll1_pkg::V_PENDING : escll1_pkg::V_REJECT;
          end
          sp--;
        end
        escll1_pkg::SYM_TP: begin
          if (tok == escll1_pkg::TK_MUL || tok == escll1_pkg::TK_DIV) begin
            return grow(escll1_pkg::SYM_TP, escll1_pkg::SYM_F) ?
                   escll1_pkg::V_PENDING : escll1_pkg::V_REJECT;
          end
          sp--;
        end
        escll1_pkg::SYM_F: begin
          if (tok == escll1_pkg::TK_ID) begin
            sp--;
            return escll1_pkg::V_PENDING;
          end
          if (tok == escll1_pkg::TK_LP) begin
            return grow(escll1_pkg::SYM_RP, escll1_pkg::SYM_E) ?
                   escll1_pkg::V_PENDING : escll1_pkg::V_REJECT;
          end
          return escll1_pkg::V_REJECT;
        end
        escll1_pkg::SYM_RP: begin
          if (tok != escll1_pkg::TK_RP) return escll1_pkg::V_REJECT;
          sp--;
          return escll1_pkg::V_PENDING;
        end
        escll1_pkg::SYM_END: begin
          return (tok == escll1_pkg::TK_END) ? escll1_pkg::V_ACCEPT : escll1_pkg::V_REJECT;
        end
        default: return escll1_pkg::V_REJECT;
      endcase
    end
    return escll1_pkg::V_REJECT;
  endfunction

  function automatic bit name_char(logic [7:0] b);
    return (b inside {[8'h41:8'h5A], [8'h61:8'h7A]}) || b >= 8'hC0;
  endfunction

  function automatic escll1_pkg::tok_t byte_token(logic [7:0] b);
    case (b)
      "+":     return escll1_pkg::TK_PLUS;
      "-":     return escll1_pkg::TK_MINUS;
      "*":     return escll1_pkg::TK_MUL;
      "/":     return escll1_pkg::TK_DIV;
      "(":     return escll1_pkg::TK_LP;
      ")":     return escll1_pkg::TK_RP;
      default: return escll1_pkg::TK_OTHER;
    endcase
  endfunction

  function automatic escll1_pkg::verdict_t parse_beat(logic [7:0] b, logic fin);
    escll1_pkg::verdict_t v;
    if (fin) begin
      v = rejected ? escll1_pkg::V_REJECT : feed_token(escll1_pkg::TK_END);
      if (v == escll1_pkg::V_PENDING) v = escll1_pkg::V_REJECT;
      restart_parse();
      return v;
    end
    if (rejected) return escll1_pkg::V_REJECT;
    if (name_char(b)) begin
      v = escll1_pkg::V_PENDING;
      if (!in_name) begin
        in_name = 1'b1;
        v = feed_token(escll1_pkg::TK_ID);
      end
    end else begin
      in_name = 1'b0;
      v = feed_token(byte_token(b));
    end
    if (v != escll1_pkg::V_PENDING) begin
      v = escll1_pkg::V_REJECT;
      rejected = 1'b1;
    end
    return v;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    escll1_pkg::verdict_t want;
    if (rst) begin
      due_verdicts.delete();
      restart_parse();
    end else begin
      if (out_valid && out_ready) begin
        if (due_verdicts.size() == 0) begin
          report_mismatch($sformatf("verdict %0d with none outstanding", verdict));
        end else begin
          want = due_verdicts.pop_front();
          if (verdict !== want) begin
            report_mismatch($sformatf("verdict %0d, predicted %0d", verdict, want));
          end
          if (want == escll1_pkg::V_ACCEPT) accepts_seen++;
        end
      end
      if (in_valid && in_ready) begin
        due_verdicts.insert(due_verdicts.size(), parse_beat(char_byte, is_end));
      end
    end
    verdicts_due = due_verdicts.size();
  end

endmodule

[tb/sv/expression_syntax_checker_ll1_unit_test.sv]
// Stimulus, handshake pacing and final verdict for the LL(1) expression checker.
`timescale 1ns / 100ps

module expression_syntax_checker_ll1_unit_test;

  localparam int DEPTH        = 64;
  localparam int CLK_PERIOD   = 8;
  localparam int RANDOM_BEATS = 1040;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 200;

  // Receiver pacing styles, each picked anew at random intervals.
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_EVERY3} rx_mode_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic [7:0] char_byte = 8'h00;
  logic       is_end    = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [1:0] verdict;
  logic       out_valid;
  logic       out_ready = 1'b0;

  int fail_count;
  int verdicts_due;
  int accepts_seen;

  int         beats_sent  = 0;
  int         exprs_sent  = 0;
  int         burst_left  = 0;
  bit         hold_req    = 1'b0;
  logic [7:0] text_q [$];

  always #(CLK_PERIOD / 2) clk = ~clk;

  expression_syntax_checker_ll1_unit #(
    .STACK_DEPTH(DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .char_byte (char_byte),
    .is_end    (is_end),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .verdict   (verdict),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

  expression_syntax_checker_ll1_unit_scoreboard #(
    .STACK_DEPTH(DEPTH)
  ) u_verdict_check (
    .clk          (clk),
    .rst          (rst),
    .char_byte    (char_byte),
    .is_end       (is_end),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .verdict      (verdict),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .fail_count   (fail_count),
    .verdicts_due (verdicts_due),
    .accepts_seen (accepts_seen)
  );

  // Append one byte to the end of the pending text.
  function automatic void add_byte(input logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side. A beat is presented with nonblocking writes at a rising edge
  // and held until an edge sees in_ready high. Between bursts valid drops for a
  // random gap; an occasional long burst gives stretches with no idling.
  // ---------------------------------------------------------------------------
  task automatic send_beat(input logic [7:0] b, input logic fin);
    char_byte <= b;
    is_end    <= fin;
    in_valid  <= 1'b1;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    if (fin) exprs_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(0, 16);
    end
  endtask

  // Close the expression held in text_q with an end marker; the byte that
  // rides along with the marker is random since the block must ignore it.
  task automatic emit_text();
    logic [7:0] junk;
    foreach (text_q[i]) send_beat(text_q[i], 1'b0);
    junk = 8'($urandom_range(0, 255));
    send_beat(junk, 1'b1);
  endtask

  task automatic send_str(input string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    emit_text();
  endtask

  // Drop valid and hold off until every predicted verdict has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdicts_due != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Text generators. They append to text_q and follow the grammar, so most of
  // the random stream gets deep into the parse table instead of dying on the
  // first byte. Identifiers mix upper, lower and the 0xC0..0xFF letter range.
  // ---------------------------------------------------------------------------
  function automatic void gen_name();
    int n;
    n = $urandom_range(1, 3);
    repeat (n) begin
      case ($urandom_range(0, 2))
        0:       add_byte(8'h41 + 8'($urandom_range(0, 25)));
        1:       add_byte(8'h61 + 8'($urandom_range(0, 25)));
        default: add_byte(8'hC0 + 8'($urandom_range(0, 63)));
      endcase
    end
  endfunction

  function automatic void gen_factor(int lvl);
    if (lvl < 3 && $urandom_range(0, 3) == 0) begin
      add_byte("(");
      gen_sum(lvl + 1);
      add_byte(")");
    end else begin
      gen_name();
    end
  endfunction

  function automatic void gen_product(int lvl);
    int n;
    n = $urandom_range(0, 2);
    gen_factor(lvl);
    repeat (n) begin
      add_byte($urandom_range(0, 1) ? "*" : "/");
      gen_factor(lvl);
    end
  endfunction

  function automatic void gen_sum(int lvl);
    int n;
    n = $urandom_range(0, 2);
    gen_product(lvl);
    repeat (n) begin
      add_byte($urandom_range(0, 1) ? "+" : "-");
      gen_product(lvl);
    end
  endfunction

  function automatic logic [7:0] pick_operator();
    string ops = "+-*/()";
    return ops[$urandom_range(0, 5)];
  endfunction

  // Break a well-formed text at one spot: overwrite, drop, insert or cut.
  function automatic void mutate_text();
    int pos;
    pos = $urandom_range(0, text_q.size() - 1);
    case ($urandom_range(0, 3))
      0:       text_q[pos] = 8'($urandom_range(0, 255));
      1:       text_q.delete(pos);
      2:       text_q.insert(pos, pick_operator());
      default: text_q = text_q[0:pos];
    endcase
  endfunction

  // Deep parentheses: each open paren leaves three stack entries, so counts
  // around twenty straddle the point where the stack runs out.
  function automatic void gen_nest();
    int n;
    n = $urandom_range(15, 23);
    repeat (n) add_byte("(");
    gen_name();
    repeat (n) add_byte(")");
  endfunction

  function automatic void gen_noise();
    int n;
    n = $urandom_range(1, 8);
    repeat (n) begin
      if ($urandom_range(0, 1)) add_byte(8'($urandom_range(0, 255)));
      else add_byte(pick_operator());
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver side. out_ready follows a pacing style that is picked anew at random
  // intervals; on request it holds low, counting the hold here, while the sender
  // keeps offering beats so that the block backs up into in_ready.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    rx_mode_t mode;
    int       left;
    int       cyc;
    mode = RX_OPEN;
    left = 0;
    cyc  = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          left = $urandom_range(16, 96);
        end
        left--;
        cyc++;
        case (mode)
          RX_OPEN:   out_ready <= 1'b1;
          RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default:   out_ready <= (cyc % 3 == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed expressions, then the random stream.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int base;
    int round;
    int roll;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: accepted forms, continued identifiers, the empty expression,
    // sticky rejection, foreign bytes, an unfinished expression, the high
    // letter range and an end marker straight after reset-state parsing.
    send_str("a+b*c");
    send_str("(x)/Yz-w");
    send_str("");
    send_str("a)+b");
    send_str("9");
    send_str("a b");
    send_str("a+");
    text_q.delete();
    add_byte(8'hC0);
    add_byte(8'hFF);
    add_byte("*");
    add_byte(8'h7A);
    add_byte("-");
    add_byte(8'h00);
    emit_text();
    // Nesting past the stack limit, then just under it.
    text_q.delete();
    repeat (21) add_byte("(");
    emit_text();
    text_q.delete();
    repeat (20) add_byte("(");
    add_byte("q");
    repeat (20) add_byte(")");
    emit_text();
    drain();

    // Random stream: mostly well-formed text with random content, the rest
    // broken, empty, nested to the limit, or plain noise.
    base  = beats_sent;
    round = 0;
    while (beats_sent - base < RANDOM_BEATS) begin
      round++;
      roll = $urandom_range(0, 99);
      if (round % 37 == 0) drain();
      if (round == 6 || round == 70) begin
        hold_req = 1'b1;
        roll = 0;
      end
      text_q.delete();
      if (roll < 60) begin
        gen_sum(0);
      end else if (roll < 75) begin
        gen_sum(0);
        mutate_text();
      end else if (roll < 83) begin
        gen_nest();
      end else if (roll < 93) begin
        gen_noise();
      end else if (roll < 96) begin
        // empty expression: end marker alone
      end else begin
        add_byte(pick_operator());
        gen_sum(0);
      end
      emit_text();
    end

    // Wind down: stop offering, wait for the last verdicts, then let the
    // block sit long enough for any stray output to show up.
    drain();
    repeat (SETTLE) @(posedge clk);
    $display("Covered %0d beats in %0d expressions, %0d of them accepted,",
             beats_sent, exprs_sent, accepts_seen);
    $display("with nesting on both sides of the stack limit and long output stalls");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #8_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
